@@ sv/ps2mpt_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared types and constants of the mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_BITS       = 13;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [DIM_BITS-1:0] WIDTH_RST  = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0] HEIGHT_RST = DIM_BITS'(768);
  localparam int POS_X_RST = 5;
  localparam int POS_Y_RST = 2;

  // header bit positions
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_MARK   = 3;
  localparam int HDR_XOVF   = 6;
  localparam int HDR_YOVF   = 7;

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_DX  = 2'd1,
    PH_DY  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] hdr;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

endpackage

@@ sv/ps2mpt_axis.sv @@
// ----------------------------------------------------------------------------
// ps2mpt_axis
// Adds a signed byte delta to one coordinate, clamps to 0..dim-1 and to the coordinate range.
// ----------------------------------------------------------------------------
module ps2mpt_axis
  import ps2mpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] pos,
  input  logic [7:0]            delta,
  input  logic [DIM_BITS-1:0]   dim,
  output logic [COORD_BITS-1:0] pos_next
);

  localparam int SW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
  localparam logic [SW-1:0] MASK_W = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

  logic signed [SW-1:0] sum;
  logic [SW-1:0]        lim_raw;
  logic [SW-1:0]        lim;

  always_comb begin
    sum = signed'({{(SW-COORD_BITS){1'b0}}, pos}) + signed'({{(SW-8){delta[7]}}, delta});
    lim_raw = (dim == '0) ? '0 : ({{(SW-DIM_BITS){1'b0}}, dim} - SW'(1));
    lim = (lim_raw > MASK_W) ? MASK_W : lim_raw;
    if (sum < 0) begin
      pos_next = '0;
    end else if (unsigned'(sum) > lim) begin
      pos_next = lim[COORD_BITS-1:0];
    end else begin
      pos_next = sum[COORD_BITS-1:0];
    end
  end

endmodule

@@ sv/ps2mpt_framer.sv @@
// ----------------------------------------------------------------------------
// ps2mpt_framer
// Input register and three-byte packet framing.
// ----------------------------------------------------------------------------
module ps2mpt_framer
  import ps2mpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_byte
  input  logic       slot_free,
  output logic       pkt_valid,
  output pkt_t       pkt
);

  logic       held;
  logic [7:0] rx;
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] hdr;
  logic [7:0] dx;
  logic       third;
  logic       fire;

  assign third    = held && (phase == PH_DY);
  assign fire     = held && (!third || slot_free);
  assign s_tready = !held || fire;
  assign pkt_valid = fire && third;
  assign pkt.hdr  = hdr;
  assign pkt.dx   = dx;
  assign pkt.dy   = rx;

  always_comb begin
    case (phase)
      PH_DX:   phase_next = PH_DY;
      PH_DY:   phase_next = PH_HDR;
      default: phase_next = rx[HDR_MARK] ? PH_DX : PH_HDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      phase <= PH_HDR;
      hdr   <= '0;
      dx    <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        held <= 1'b1;
      end else if (fire) begin
        held <= 1'b0;
      end
      if (fire) begin
        phase <= phase_next;
        if (phase == PH_DX) begin
          dx <= rx;
        end else if (phase != PH_DY && rx[HDR_MARK]) begin
          hdr <= rx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx <= s_tdata;
    end
  end

endmodule

@@ sv/ps2_mouse_packet_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// Frames PS/2 mouse bytes into three-byte packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the input is not stalled. The clock edge
// that takes a byte loads it into the input register. The third byte of a
// packet then moves from there, through the framing and cursor update logic,
// into the result register once the result slot is free. The sustained rate
// is one byte per cycle while results are taken. A third byte stalls the input
// only while an earlier result is still waiting on the output.
// Headers without the always-one marker bit are dropped. Packets with an
// overflow bit set report the old position with the discarded flag.
module ps2_mouse_packet_tracker_unit
  import ps2mpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,    // rx_byte
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // cursor_x, cursor_y, left_pressed, right_pressed, middle_pressed,
  // discarded, zero fill
  output logic [((2*COORD_BITS+4+7)/8)*8-1:0] m_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data
);

  localparam int OUT_W = ((2*COORD_BITS+4+7)/8)*8;

  logic [DIM_BITS-1:0]   width;
  logic [DIM_BITS-1:0]   height;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic [COORD_BITS-1:0] new_x;
  logic [COORD_BITS-1:0] new_y;
  logic                  slot_free;
  logic                  pkt_valid;
  pkt_t                  pkt;
  logic                  drop;

  assign cfg_ready = 1'b1;
  assign slot_free = !m_tvalid || m_tready;

  ps2mpt_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .slot_free (slot_free),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  ps2mpt_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .pos      (pos_x),
    .delta    (pkt.dx),
    .dim      (width),
    .pos_next (new_x)
  );

  ps2mpt_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .pos      (pos_y),
    .delta    (pkt.dy),
    .dim      (height),
    .pos_next (new_y)
  );

  assign drop       = pkt.hdr[HDR_XOVF] || pkt.hdr[HDR_YOVF];
  assign pos_x_next = drop ? pos_x : new_x;
  assign pos_y_next = drop ? pos_y : new_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      width    <= WIDTH_RST;
      height   <= HEIGHT_RST;
      pos_x    <= COORD_BITS'(POS_X_RST);
      pos_y    <= COORD_BITS'(POS_Y_RST);
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) begin
          width <= cfg_data;
        end else if (cfg_index == REG_HEIGHT) begin
          height <= cfg_data;
        end
      end
      if (pkt_valid) begin
        pos_x    <= pos_x_next;
        pos_y    <= pos_y_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid) begin
      m_tdata <= OUT_W'({drop, pkt.hdr[HDR_MIDDLE], pkt.hdr[HDR_RIGHT],
                         pkt.hdr[HDR_LEFT], pos_y_next, pos_x_next});
    end
  end

endmodule

@@ sv/ps2mpt_checker.sv @@
// ----------------------------------------------------------------------------
// ps2mpt_checker
// Port-level checks on the mouse packet tracker.
// ----------------------------------------------------------------------------
module ps2mpt_checker
  import ps2mpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((2*COORD_BITS+4+7)/8)*8-1:0]   m_tdata,
  input logic                                  cfg_ready
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_no_result_after_rst: assert property (@(posedge clk)
    $rose(m_tvalid) |-> !$past(rst))
    else $error("result right after reset");

  // input only stalls behind a waiting result
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with free result slot");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker #(.COORD_BITS(COORD_BITS)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);
